// ===== sv/prtb_pkg.sv =====
// Shared types and constants for the packet rate token bucket unit.
// Used by prtb_sub, prtb_engine and packet_rate_token_bucket_unit; depends on nothing.
`default_nettype none

package prtb_pkg;

  // Field widths
  localparam int RATE_W    = 16;
  localparam int SIZE_W    = 11;
  localparam int CREDIT_W  = 17;
  localparam int ELAPSED_W = 32;
  localparam int ROOM_W    = 7;
  localparam int ERR_W     = 8;
  localparam int COUNT_W   = 32;
  localparam int BYTES_W   = 64;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  // Limits
  localparam logic [RATE_W-1:0] MAX_RATE  = 16'd50000;
  localparam logic [SIZE_W-1:0] MIN_SIZE  = 11'd16;
  localparam logic [SIZE_W-1:0] MAX_SIZE  = 11'd1472;
  localparam int                MAX_SENDS_DEF = 64;

  // Highest credit any running rate can bank: 50000 * 20 / 8 + 1472
  localparam logic [CREDIT_W-1:0] CREDIT_MAX = 17'd126472;

  // Earned credit is rate * elapsed / 8000; the product is 48 bits wide.
  localparam int PROD_W  = RATE_W + ELAPSED_W;
  localparam int DIVISOR = 8000;
  localparam int QBITS   = CREDIT_W;
  // A product at or above this gives at least 2^17 bytes, beyond any ceiling.
  localparam logic [PROD_W-1:0] BIG_PRODUCT = PROD_W'(64'(DIVISOR) << QBITS);

  // Divide by 8000 as a shift by 6 and a divide by 125. Below BIG_PRODUCT the
  // shifted product fits 24 bits, and multiplying by ceil(2^31 / 125) then
  // shifting right by 31 gives the exact quotient over that whole range.
  localparam int                 PRE_SHIFT   = 6;
  localparam int                 X_W         = 24;
  localparam int                 RECIP_W     = 25;
  localparam int                 MUL_W       = X_W + RECIP_W;
  localparam int                 RECIP_SHIFT = 31;
  localparam logic [RECIP_W-1:0] RECIP_125   = 25'd17179870;

  // Width of the shared subtract unit
  localparam int SUB_W = CREDIT_W + 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_START = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STOPPED   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]      opcode;
    logic [ELAPSED_W-1:0] delta_us;
    logic                 link_up;
    logic [ROOM_W-1:0]    send_room;
    logic [ERR_W-1:0]     error_code;
  } prtb_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ROOM_W-1:0]   sent_now;
    logic                failed_now;
    logic                is_running;
    logic [CREDIT_W-1:0] credit_left;
    logic [COUNT_W-1:0]  sent_total;
    logic [COUNT_W-1:0]  fail_total;
    logic [COUNT_W-1:0]  down_total;
    logic [BYTES_W-1:0]  bytes_total;
    logic [ERR_W-1:0]    last_error;
  } prtb_result_t;

endpackage

`default_nettype wire

// ===== sv/prtb_sub.sv =====
// Shared compare and subtract unit of the token bucket engine.
// Depends on prtb_pkg for the operand width.
`default_nettype none

module prtb_sub import prtb_pkg::*; (
  input  wire logic [SUB_W-1:0] a,
  input  wire logic [SUB_W-1:0] b,
  output logic [SUB_W-1:0]      diff,
  output logic                  ge
);

  logic borrow;

  // One subtraction serves both the difference and the a >= b test.
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = ~borrow;

endmodule

`default_nettype wire

// ===== sv/prtb_engine.sv =====
// Sequencer and state of the token bucket: start and stop handling, credit earning
// through a reciprocal multiply for the divide by 8000, and the per-packet send loop.
// Depends on prtb_pkg and prtb_sub.
`default_nettype none

module prtb_engine import prtb_pkg::*; #(
  parameter int MAX_SENDS_PER_TICK = MAX_SENDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire prtb_item_t        in_item,
  input  wire logic [RATE_W-1:0] cfg_rate,
  input  wire logic [SIZE_W-1:0] cfg_size,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output prtb_result_t           res
);

  localparam int CNT_W = $clog2(MAX_SENDS_PER_TICK + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SENDS_PER_TICK);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MULD, S_ADD, S_SEND, S_FIN
  } state_t;

  state_t state;

  // Architectural state
  logic                running;
  logic [RATE_W-1:0]   active_rate;
  logic [SIZE_W-1:0]   active_size;
  logic [CREDIT_W-1:0] credit;
  logic [COUNT_W-1:0]  sent_count;
  logic [COUNT_W-1:0]  fail_count;
  logic [COUNT_W-1:0]  down_count;
  logic [BYTES_W-1:0]  byte_count;
  logic [ERR_W-1:0]    latched_error;

  // Per-item working registers
  prtb_item_t          item;
  logic [STATUS_W-1:0] status;
  logic                failed;
  logic [CNT_W-1:0]    sends;
  logic [PROD_W-1:0]   product;
  logic [CREDIT_W-1:0] ceiling;
  logic [QBITS-1:0]    quo;
  logic [CREDIT_W-1:0] bank;

  // Shared unit operands
  logic [SUB_W-1:0] sub_a;
  logic [SUB_W-1:0] sub_b;
  logic [SUB_W-1:0] sub_diff;
  logic             sub_ge;

  logic [SUB_W-1:0] sum;
  logic [SUB_W-1:0] rate5;
  logic [SUB_W-1:0] ceil_calc;
  logic [MUL_W-1:0] recip_prod;
  logic             bad_start;

  prtb_sub u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  // Credit plus earned bytes, the bank ceiling rate * 20 / 8 + size, and the
  // reciprocal product whose upper bits are the product divided by 8000.
  always_comb begin
    sum        = {1'b0, credit} + {1'b0, quo};
    rate5      = {active_rate, 2'b00} + SUB_W'(active_rate);
    ceil_calc  = {1'b0, rate5[SUB_W-1:1]} + SUB_W'(active_size);
    recip_prod = MUL_W'(product[PRE_SHIFT +: X_W]) * MUL_W'(RECIP_125);
    bad_start = (cfg_rate > MAX_RATE) || (cfg_size < MIN_SIZE) || (cfg_size > MAX_SIZE);
  end

  // Operand selection for the shared unit by sequencer state.
  always_comb begin
    case (state)
      S_ADD: begin
        sub_a = SUB_W'(ceiling);
        sub_b = sum;
      end
      S_SEND: begin
        sub_a = SUB_W'(bank);
        sub_b = SUB_W'(active_size);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FIN);

  always_comb begin
    res.status      = status;
    res.sent_now    = ROOM_W'(sends);
    res.failed_now  = failed;
    res.is_running  = running;
    res.credit_left = credit;
    res.sent_total  = sent_count;
    res.fail_total  = fail_count;
    res.down_total  = down_count;
    res.bytes_total = byte_count;
    res.last_error  = latched_error;
  end

  // Sequencer with all state and registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running       <= 1'b0;
      active_rate   <= '0;
      active_size   <= MAX_SIZE;
      credit        <= '0;
      sent_count    <= '0;
      fail_count    <= '0;
      down_count    <= '0;
      byte_count    <= '0;
      latched_error <= '0;
      status        <= ST_DONE;
      failed        <= 1'b0;
      sends         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item   <= in_item;
            status <= ST_DONE;
            failed <= 1'b0;
            sends  <= '0;
            state  <= S_EXEC;
          end
        end

        S_EXEC: begin
          case (item.opcode)
            OP_START: begin
              if (cfg_rate == '0) begin
                running     <= 1'b0;
                active_rate <= '0;
                state       <= S_FIN;
              end else if (bad_start) begin
                status <= ST_BAD_START;
                state  <= S_FIN;
              end else begin
                if (!running) begin
                  sent_count    <= '0;
                  fail_count    <= '0;
                  down_count    <= '0;
                  byte_count    <= '0;
                  latched_error <= '0;
                end
                running     <= 1'b1;
                active_rate <= cfg_rate;
                active_size <= cfg_size;
                credit      <= '0;
                state       <= S_FIN;
              end
            end
            OP_TICK: begin
              if (!running) begin
                status <= ST_STOPPED;
                state  <= S_FIN;
              end else if (!item.link_up) begin
                down_count <= down_count + 1'b1;
                credit     <= '0;
                state      <= S_FIN;
              end else begin
                product <= PROD_W'(active_rate) * PROD_W'(item.delta_us);
                ceiling <= ceil_calc[CREDIT_W-1:0];
                state   <= S_MULD;
              end
            end
            default: begin
              // Stop, and the unused code, which acts as a stop.
              running     <= 1'b0;
              active_rate <= '0;
              state       <= S_FIN;
            end
          endcase
        end

        S_MULD: begin
          if (product >= BIG_PRODUCT) begin
            // Earned credit alone overflows the bank.
            bank  <= ceiling;
            state <= S_SEND;
          end else begin
            quo   <= recip_prod[RECIP_SHIFT +: QBITS];
            state <= S_ADD;
          end
        end

        S_ADD: begin
          bank  <= sub_ge ? sum[CREDIT_W-1:0] : ceiling;
          state <= S_SEND;
        end

        S_SEND: begin
          // One packet attempt per cycle while the bank covers a packet and the per-tick limit is not reached.
          if ((sends < CNT_MAX) && sub_ge) begin
            bank <= sub_diff[CREDIT_W-1:0];
            if (ROOM_W'(sends) >= item.send_room) begin
              fail_count    <= fail_count + 1'b1;
              latched_error <= item.error_code;
              failed        <= 1'b1;
              credit        <= sub_diff[CREDIT_W-1:0];
              state         <= S_FIN;
            end else begin
              sent_count <= sent_count + 1'b1;
              byte_count <= byte_count + BYTES_W'(active_size);
              sends      <= sends + 1'b1;
            end
          end else begin
            credit <= bank;
            state  <= S_FIN;
          end
        end

        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The bank never holds more than the largest ceiling.
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= CREDIT_MAX)
    else $error("credit above the largest bank ceiling");

  // A running bucket always holds a rate that passed the start check.
  a_rate_valid: assert property (@(posedge clk) disable iff (rst)
    running |-> (active_rate != '0) && (active_rate <= MAX_RATE))
    else $error("running with an invalid rate");

  // A refused send happens exactly at the attempt after the room is used up.
  a_fail_at_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && failed |-> (ROOM_W'(sends) == item.send_room))
    else $error("refused send at the wrong attempt");

  // The attempt counter never passes the per-tick limit.
  a_send_limit: assert property (@(posedge clk) disable iff (rst)
    sends <= CNT_MAX)
    else $error("send count above the per-tick limit");

endmodule

`default_nettype wire

// ===== sv/packet_rate_token_bucket_unit.sv =====
// Packet rate token bucket unit: stream ports, configuration registers and result register.
// Depends on prtb_pkg and prtb_engine.
//
// Credit pacer for fixed-size packets. A start item latches the configured rate and
// packet size after checking them, a stop item halts pacing, and each tick earns
// rate*elapsed/8000 bytes of credit and spends it on up to MAX_SENDS_PER_TICK packets.
// Items are handled one at a time. Start and stop items, and ticks while stopped or
// with the link down, go from the execute state straight to the result. A tick with
// the link up multiplies rate by elapsed time, divides by 8000 through a reciprocal
// multiply, clamps the credit to the bank ceiling, and then makes its packet attempts,
// at most MAX_SENDS_PER_TICK of them, on the shared subtract unit. A refused attempt
// ends the tick, and a tick whose earned credit already fills the bank skips the clamp
// step.
// The next input transfer is taken while a finished result still waits on the output.
`default_nettype none

module packet_rate_token_bucket_unit import prtb_pkg::*; #(
  parameter int MAX_SENDS_PER_TICK = MAX_SENDS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [47:0]          s_tdata,   // delta_us, link_up, send_room, error_code
  input  wire logic [OP_W-1:0]      s_tuser,   // opcode
  // Result stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // sent_now, failed_now, is_running, credit_left, sent_total, fail_total,
  // down_total, bytes_total, last_error, zero fill
  output logic [199:0]              m_tdata,
  output logic [STATUS_W-1:0]       m_tuser,   // status
  // Configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RATE_W-1:0]    cfg_data
);

  logic [RATE_W-1:0] rate_kbps;
  logic [SIZE_W-1:0] packet_bytes;

  prtb_item_t   in_item;
  prtb_result_t res;
  logic         res_valid;
  logic         res_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_kbps    <= '0;
      packet_bytes <= MAX_SIZE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE: rate_kbps    <= cfg_data;
        REG_SIZE: packet_bytes <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input transfer.
  always_comb begin
    in_item.opcode     = s_tuser;
    in_item.delta_us   = s_tdata[31:0];
    in_item.link_up    = s_tdata[32];
    in_item.send_room  = s_tdata[39:33];
    in_item.error_code = s_tdata[47:40];
  end

  prtb_engine #(
    .MAX_SENDS_PER_TICK (MAX_SENDS_PER_TICK)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .cfg_rate  (rate_kbps),
    .cfg_size  (packet_bytes),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: loads when empty or when its result is being taken.
  assign res_ready = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tuser <= res.status;
      m_tdata <= {6'b0, res.last_error, res.bytes_total, res.down_total,
                  res.fail_total, res.sent_total, res.credit_left, res.is_running,
                  res.failed_now, res.sent_now};
    end
  end

endmodule

`default_nettype wire

// ===== tb/packet_rate_token_bucket_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for packet_rate_token_bucket_unit: directed start, stop and tick
// cases, then randomized pacing phases checked against an in-bench credit pacer model.
// Depends on prtb_pkg and the packet_rate_token_bucket_unit RTL.

module packet_rate_token_bucket_unit_tb;
  import prtb_pkg::*;

  // The fourth opcode value has no name in the package; the block treats it as a stop.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASES       = 20;
  localparam int PHASE_ITEMS  = 24;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [47:0]          s_tdata = '0;
  logic [OP_W-1:0]      s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [199:0]         m_tdata;
  logic [STATUS_W-1:0]  m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RATE_W-1:0]    cfg_data = '0;

  // Items waiting to be driven and pacer reports waiting to be seen.
  prtb_item_t   pending_items[$];
  prtb_result_t expected_reports[$];
  prtb_item_t   shown_item = '0;
  prtb_result_t got_report;
  prtb_result_t want_report;

  // Register copies and pacer state, at their reset values.
  logic [RATE_W-1:0]   cfg_rate = '0;
  logic [SIZE_W-1:0]   cfg_size = MAX_SIZE;
  logic                run_on = 1'b0;
  logic [RATE_W-1:0]   cur_rate = '0;
  logic [SIZE_W-1:0]   cur_size = MAX_SIZE;
  logic [CREDIT_W-1:0] bank = '0;
  logic [COUNT_W-1:0]  sent_cnt = '0;
  logic [COUNT_W-1:0]  fail_cnt = '0;
  logic [COUNT_W-1:0]  down_cnt = '0;
  logic [BYTES_W-1:0]  byte_cnt = '0;
  logic [ERR_W-1:0]    err_latch = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int items_in = 0;
  int results_checked = 0;
  int settings_used = 0;
  int paced_packets = 0;
  int refused_sends = 0;
  int down_ticks = 0;
  int refused_starts = 0;

  packet_rate_token_bucket_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // A stop only has an effect while pacing runs; the credit stays banked.
  function automatic void stop_pacing();
    if (run_on) begin
      run_on = 1'b0;
      cur_rate = '0;
    end
  endfunction

  // Applies one item to the pacer state and returns the report it produces.
  function automatic prtb_result_t pace_item(input prtb_item_t it);
    prtb_result_t r;
    logic [63:0]  earned;
    logic [63:0]  ceiling;
    logic [63:0]  c;
    int unsigned  k;
    r = '0;
    case (it.opcode)
      OP_START: begin
        if (cfg_rate == '0) begin
          stop_pacing();
        end else if (cfg_rate > MAX_RATE || cfg_size < MIN_SIZE || cfg_size > MAX_SIZE) begin
          r.status = ST_BAD_START;
          refused_starts++;
        end else begin
          // Totals restart only when coming out of the stopped state.
          if (!run_on) begin
            sent_cnt = '0;
            fail_cnt = '0;
            down_cnt = '0;
            byte_cnt = '0;
            err_latch = '0;
          end
          run_on = 1'b1;
          cur_rate = cfg_rate;
          cur_size = cfg_size;
          bank = '0;
        end
      end
      OP_TICK: begin
        if (!run_on) begin
          r.status = ST_STOPPED;
        end else begin
          earned = (64'(cur_rate) * 64'(it.delta_us)) / 64'd8000;
          ceiling = 64'(cur_rate) * 64'd20 / 64'd8 + 64'(cur_size);
          c = 64'(bank) + earned;
          if (c > ceiling) c = ceiling;
          if (!it.link_up) begin
            down_cnt++;
            down_ticks++;
            bank = '0;
          end else begin
            // Every attempt costs one packet of credit, a refused one too.
            for (k = 0; k < MAX_SENDS_DEF; k++) begin
              if (c < 64'(cur_size)) break;
              c = c - 64'(cur_size);
              if (k >= it.send_room) begin
                fail_cnt++;
                err_latch = it.error_code;
                r.failed_now = 1'b1;
                refused_sends++;
                break;
              end
              sent_cnt++;
              r.sent_now = r.sent_now + 1'b1;
              byte_cnt = byte_cnt + 64'(cur_size);
              paced_packets++;
            end
            bank = c[CREDIT_W-1:0];
          end
        end
      end
      default: begin
        stop_pacing();
      end
    endcase
    r.is_running = run_on;
    r.credit_left = bank;
    r.sent_total = sent_cnt;
    r.fail_total = fail_cnt;
    r.down_total = down_cnt;
    r.bytes_total = byte_cnt;
    r.last_error = err_latch;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Input driver: predicts each accepted transfer, then offers the next pending item.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_reports.push_back(pace_item(shown_item));
        items_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          shown_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {shown_item.error_code, shown_item.send_room, shown_item.link_up,
                      shown_item.delta_us};
          s_tuser <= shown_item.opcode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each output transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_report.status = m_tuser;
        got_report.sent_now = m_tdata[6:0];
        got_report.failed_now = m_tdata[7];
        got_report.is_running = m_tdata[8];
        got_report.credit_left = m_tdata[25:9];
        got_report.sent_total = m_tdata[57:26];
        got_report.fail_total = m_tdata[89:58];
        got_report.down_total = m_tdata[121:90];
        got_report.bytes_total = m_tdata[185:122];
        got_report.last_error = m_tdata[193:186];
        if (expected_reports.size() == 0) begin
          $display("%0t ns: result expected none, got status %0d data %h", $time, m_tuser,
                   m_tdata);
          mismatches++;
        end else begin
          want_report = expected_reports.pop_front();
          check_field("status", 64'(want_report.status), 64'(got_report.status));
          check_field("sent_now", 64'(want_report.sent_now), 64'(got_report.sent_now));
          check_field("failed_now", 64'(want_report.failed_now),
                      64'(got_report.failed_now));
          check_field("is_running", 64'(want_report.is_running),
                      64'(got_report.is_running));
          check_field("credit_left", 64'(want_report.credit_left),
                      64'(got_report.credit_left));
          check_field("sent_total", 64'(want_report.sent_total),
                      64'(got_report.sent_total));
          check_field("fail_total", 64'(want_report.fail_total),
                      64'(got_report.fail_total));
          check_field("down_total", 64'(want_report.down_total),
                      64'(got_report.down_total));
          check_field("bytes_total", want_report.bytes_total, got_report.bytes_total);
          check_field("last_error", 64'(want_report.last_error),
                      64'(got_report.last_error));
        end
        results_checked++;
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Cycles without any transfer on either stream.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a long silence on both streams means a hang.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Watchdog: no transfer for %0d cycles, %0d reports outstanding", QUIET_LIMIT,
             expected_reports.size());
    $display("packet_rate_token_bucket_unit: mismatch");
    $finish;
  end

  task automatic queue_item(input logic [OP_W-1:0] op, input logic [ELAPSED_W-1:0] elapsed,
                            input logic link, input logic [ROOM_W-1:0] room,
                            input logic [ERR_W-1:0] err);
    prtb_item_t it;
    it.opcode = op;
    it.delta_us = elapsed;
    it.link_up = link;
    it.send_room = room;
    it.error_code = err;
    pending_items.push_back(it);
  endtask

  // Sampled at the falling edge so that no driver update of this cycle is missed.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_reports.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RATE) begin
      cfg_rate = val;
    end else begin
      cfg_size = val[SIZE_W-1:0];
    end
  endtask

  // Registers change only once the block has gone idle.
  task automatic configure(input logic [RATE_W-1:0] rate, input logic [RATE_W-1:0] size);
    wait_quiet();
    write_reg(REG_RATE, rate);
    write_reg(REG_SIZE, size);
    settings_used++;
  endtask

  initial begin
    int unsigned     p;
    int unsigned     n;
    int unsigned     pick;
    int unsigned     rate;
    int unsigned     size;
    logic [63:0]     span;
    logic [OP_W-1:0] op;
    logic [31:0]     elapsed;
    logic [6:0]      room;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: tick while stopped, stop while stopped, zero-rate start, spare opcode.
    queue_item(OP_TICK, 32'hFFFF_FFFF, 1'b1, 7'd127, 8'hFF);
    queue_item(OP_STOP, 32'd0, 1'b0, 7'd0, 8'd0);
    queue_item(OP_START, 32'd100, 1'b1, 7'd64, 8'd1);
    queue_item(OP_SPARE, 32'd5, 1'b1, 7'd3, 8'd2);

    // Starts refused for a rate or a size out of range.
    configure(16'hFFFF, 16'(MAX_SIZE));
    queue_item(OP_START, 32'd0, 1'b1, 7'd1, 8'd0);
    configure(16'd50001, 16'(MAX_SIZE));
    queue_item(OP_START, 32'd0, 1'b1, 7'd1, 8'd0);
    configure(16'(MAX_RATE), 16'd15);
    queue_item(OP_START, 32'd0, 1'b1, 7'd1, 8'd0);
    configure(16'(MAX_RATE), 16'd1473);
    queue_item(OP_START, 32'd0, 1'b1, 7'd1, 8'd0);

    // Fastest setting: full bank, send cap, refusal, link down, stop keeps the credit.
    configure(16'(MAX_RATE), 16'(MIN_SIZE));
    queue_item(OP_START, 32'd0, 1'b1, 7'd0, 8'd0);
    queue_item(OP_TICK, 32'hFFFF_FFFF, 1'b1, 7'd127, 8'hFF);
    queue_item(OP_TICK, 32'd0, 1'b1, 7'd0, 8'hA5);
    queue_item(OP_TICK, 32'd5000, 1'b0, 7'd64, 8'h11);
    queue_item(OP_TICK, 32'd1000, 1'b1, 7'd64, 8'h22);
    queue_item(OP_STOP, 32'd0, 1'b1, 7'd0, 8'd0);
    queue_item(OP_TICK, 32'd1000, 1'b1, 7'd64, 8'd0);
    queue_item(OP_STOP, 32'd0, 1'b1, 7'd0, 8'd0);

    // Slowest rate at the largest size: restart clears totals, one refused attempt.
    configure(16'd1, 16'(MAX_SIZE));
    queue_item(OP_START, 32'd0, 1'b1, 7'd0, 8'd0);
    queue_item(OP_TICK, 32'hFFFF_FFFF, 1'b1, 7'd0, 8'h5A);
    queue_item(OP_TICK, 32'd0, 1'b1, 7'd1, 8'd0);

    // Start while running keeps the totals.
    configure(16'd8000, 16'd1000);
    queue_item(OP_START, 32'd0, 1'b1, 7'd0, 8'd0);
    queue_item(OP_TICK, 32'd1000, 1'b1, 7'd5, 8'd0);
    queue_item(OP_SPARE, 32'd0, 1'b0, 7'd0, 8'd0);

    // Random phases: each picks a setting and an idling pattern, then paces a run.
    for (p = 0; p < PHASES; p++) begin
      pick = $urandom_range(99);
      if (pick < 5) rate = 0;
      else if (pick < 10) rate = $urandom_range(65535, 50001);
      else if (pick < 18) rate = 32'(MAX_RATE);
      else if (pick < 25) rate = 1;
      else rate = $urandom_range(50000, 1);
      pick = $urandom_range(99);
      if (pick < 4) size = $urandom_range(15, 0);
      else if (pick < 8) size = $urandom_range(2047, 1473);
      else if (pick < 18) size = 32'(MIN_SIZE);
      else if (pick < 28) size = 32'(MAX_SIZE);
      else size = $urandom_range(1472, 16);
      // Bits above the size register are sometimes set in the write data.
      if ($urandom_range(9) == 0) size = size | ($urandom_range(31) << SIZE_W);
      configure(rate[15:0], size[15:0]);

      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 68;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 68;
        end
        default: begin
          send_idle_pct = 25;
          recv_stall_pct = 25;
        end
      endcase

      queue_item(OP_START, $urandom, 1'b1, 7'($urandom_range(127)), 8'($urandom_range(255)));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Now and then the sender holds off until every report is back.
        if (p % 3 == 1 && n == PHASE_ITEMS / 2) wait_quiet();

        pick = $urandom_range(99);
        if (pick < 82) op = OP_TICK;
        else if (pick < 89) op = OP_START;
        else if (pick < 95) op = OP_STOP;
        else op = OP_SPARE;

        // Elapsed time mostly sized to earn a handful of packets.
        pick = $urandom_range(99);
        if (pick < 6) begin
          elapsed = 32'd0;
        end else if (pick < 16) begin
          elapsed = $urandom;
        end else if (pick < 24) begin
          elapsed = $urandom_range(40);
        end else begin
          if (cfg_rate == '0) begin
            span = 64'd200000;
          end else begin
            span = 64'(cfg_size) * 64'd8000 * 64'($urandom_range(70)) / 64'(cfg_rate);
          end
          if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
          elapsed = $urandom_range(span[31:0]);
        end

        pick = $urandom_range(99);
        if (pick < 55) room = 7'($urandom_range(64));
        else if (pick < 70) room = 7'd0;
        else if (pick < 85) room = 7'd64;
        else room = 7'($urandom_range(127, 65));

        queue_item(op, elapsed, ($urandom_range(9) != 0), room, 8'($urandom_range(255)));
      end
    end

    // Let the last reports come back, then give the block time for anything stray.
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $display("%0t ns: %0d reports expected but never seen", $time, expected_reports.size());
      mismatches++;
    end

    $display("Ran %0d items through %0d register settings; %0d reports compared.",
             items_in, settings_used, results_checked);
    $display("Seen: %0d packets paced, %0d refused sends, %0d link-down ticks, %0d bad starts.",
             paced_packets, refused_sends, down_ticks, refused_starts);
    if (mismatches == 0) begin
      $display("packet_rate_token_bucket_unit: match");
    end else begin
      $display("packet_rate_token_bucket_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/prtb_pkg.sv
sv/prtb_sub.sv
sv/prtb_engine.sv
sv/packet_rate_token_bucket_unit.sv
tb/packet_rate_token_bucket_unit_tb.sv
